### rtl/clsq_pkg.sv
package clsq_pkg;

  typedef enum logic [1:0] {
    MODE_CMD  = 2'd0,
    MODE_CHAR = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_GOTO = 2'd3
  } mode_e;

  localparam logic [1:0] CFG_FOUR_BIT  = 2'd0;
  localparam logic [1:0] CFG_INIT_DONE = 2'd1;
  localparam logic [1:0] CFG_ROW2_ADDR = 2'd2;

  localparam int VALUE_W    = 16;
  localparam int BCD_DIGITS = 5;
  localparam int BCD_W      = 4 * BCD_DIGITS;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] GOTO_CMD   = 8'h80;

  typedef struct packed {
    logic busy;
    logic done;
  } bcd_status_t;

endpackage

### rtl/clsq_bcd.sv
module clsq_bcd
  import clsq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [VALUE_W-1:0] value_i,
  output bcd_status_t        status_o,
  output logic [BCD_W-1:0]   bcd_o
);

  logic [VALUE_W-1:0] bin_q;
  logic [BCD_W-1:0]   bcd_q;
  logic [BCD_W-1:0]   adj;
  logic [3:0]         cnt_q;
  logic               busy_q;
  logic               done_q;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd_q[4*k +: 4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'(VALUE_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 4'd1;
        end
      end
    end
  end

  // one input bit per cycle, msb first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
      bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign bcd_o         = bcd_q;

endmodule

### rtl/char_lcd_write_sequencer_core.sv
// first transfer: for a command, character or in-range goto item it is registered
// from the emit state once the output register is free; a number first passes the
// bit-serial conversion and the leading-zero digit scan before it reaches that state
// throughput: within an item, one transfer per cycle while m_axis_tready is high;
// the next item is taken once the item's last transfer sits in the output register
// reset: four-bit mode on, init done, second row at address 64, no item pending
module char_lcd_write_sequencer_core
  import clsq_pkg::*;
#(
  parameter int ROW_LENGTH = 16,
  parameter int ROW_COUNT  = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // value[15:0], row[17:16], col[22:18], zero[23]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // bus_value[7:0]
  output logic        m_axis_tuser,   // reg_select[0]
  output logic        m_axis_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

  state_e             state_q;
  logic               four_bit_q;
  logic               init_q;
  logic [6:0]         row2_q;
  logic [7:0]         byte_q;
  logic               rs_q;
  logic               cmd_q;
  logic               phase_q;
  logic [2:0]         left_q;
  logic [BCD_W-1:0]   dig_q;
  logic               out_valid_q;
  logic [7:0]         out_data_q;
  logic               out_rs_q;
  logic               out_last_q;

  mode_e              in_mode;
  logic [15:0]        in_value;
  logic [1:0]         in_row;
  logic [4:0]         in_col;
  logic               accept;
  logic               goto_ok;
  logic [7:0]         goto_sum;
  logic               bcd_start;
  bcd_status_t        bcd_st;
  logic [BCD_W-1:0]   bcd_val;
  logic               out_free;
  logic               byte_end;
  logic [7:0]         xfer;
  logic [3:0]         top_dig;

  assign in_mode  = mode_e'(s_axis_tuser);
  assign in_value = s_axis_tdata[15:0];
  assign in_row   = s_axis_tdata[17:16];
  assign in_col   = s_axis_tdata[22:18];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign bcd_start     = accept && (in_mode == MODE_NUM);

  assign goto_ok  = (32'(in_row) < ROW_COUNT) && (32'(in_col) < ROW_LENGTH);
  assign goto_sum = 8'(({7'd0, in_row} * {2'd0, row2_q}) + {4'd0, in_col});

  assign top_dig  = dig_q[BCD_W-1 -: 4];
  assign out_free = !out_valid_q || m_axis_tready;
  // a command before init in four-bit mode ends after its high nibble
  assign byte_end = !four_bit_q || phase_q || (cmd_q && !init_q);

  always_comb begin
    if (!four_bit_q) begin
      xfer = byte_q;
    end else if (phase_q) begin
      xfer = {byte_q[3:0], 4'd0};
    end else begin
      xfer = {byte_q[7:4], 4'd0};
    end
  end

  clsq_bcd u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (bcd_start),
    .value_i  (in_value),
    .status_o (bcd_st),
    .bcd_o    (bcd_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      four_bit_q  <= 1'b1;
      init_q      <= 1'b1;
      row2_q      <= 7'd64;
      byte_q      <= '0;
      rs_q        <= 1'b0;
      cmd_q       <= 1'b0;
      phase_q     <= 1'b0;
      left_q      <= '0;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_rs_q    <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FOUR_BIT:  four_bit_q <= cfg_data_i[0];
          CFG_INIT_DONE: init_q     <= cfg_data_i[0];
          CFG_ROW2_ADDR: row2_q     <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            phase_q <= 1'b0;
            left_q  <= 3'd1;
            unique case (in_mode)
              MODE_CMD: begin
                byte_q  <= in_value[7:0];
                rs_q    <= 1'b0;
                cmd_q   <= 1'b1;
                state_q <= ST_EMIT;
              end
              MODE_CHAR: begin
                byte_q  <= in_value[7:0];
                rs_q    <= 1'b1;
                cmd_q   <= 1'b0;
                state_q <= ST_EMIT;
              end
              MODE_NUM: begin
                rs_q    <= 1'b1;
                cmd_q   <= 1'b0;
                state_q <= ST_CONV;
              end
              MODE_GOTO: begin
                byte_q <= goto_sum | GOTO_CMD;
                rs_q   <= 1'b0;
                cmd_q  <= 1'b1;
                if (goto_ok) begin
                  state_q <= ST_EMIT;
                end
              end
            endcase
          end
        end
        ST_CONV: begin
          if (bcd_st.done) begin
            dig_q   <= bcd_val;
            left_q  <= 3'(BCD_DIGITS);
            state_q <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // drop leading zero digits, keep at least the units digit
          if (top_dig == 4'd0 && left_q > 3'd1) begin
            dig_q  <= {dig_q[BCD_W-5:0], 4'd0};
            left_q <= left_q - 3'd1;
          end else begin
            byte_q  <= ASCII_ZERO | {4'd0, top_dig};
            dig_q   <= {dig_q[BCD_W-5:0], 4'd0};
            phase_q <= 1'b0;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_data_q  <= xfer;
            out_rs_q    <= rs_q;
            out_last_q  <= byte_end && (left_q == 3'd1);
            if (!byte_end) begin
              phase_q <= 1'b1;
            end else if (left_q == 3'd1) begin
              state_q <= ST_IDLE;
            end else begin
              byte_q  <= ASCII_ZERO | {4'd0, top_dig};
              dig_q   <= {dig_q[BCD_W-5:0], 4'd0};
              left_q  <= left_q - 3'd1;
              phase_q <= 1'b0;
            end
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_rs_q;
  assign m_axis_tlast  = out_last_q;

  a_bcd_done_in_conv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bcd_st.busy || bcd_st.done) |-> state_q == ST_CONV)
    else $error("digit conversion running outside conversion state");

  a_emit_has_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT || state_q == ST_SKIP) |-> left_q != 3'd0)
    else $error("emitting with no bytes left");

  a_last_ends_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && byte_end && left_q == 3'd1)
      |=> (state_q == ST_IDLE && out_valid_q && out_last_q))
    else $error("final transfer not marked last or item not closed");

  a_digit_is_decimal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SKIP |-> top_dig <= 4'd9)
    else $error("number digit out of decimal range");

endmodule

### tb/char_lcd_write_sequencer_core_tb.sv
`timescale 1ns / 1ps

module char_lcd_write_sequencer_core_tb;
  import clsq_pkg::*;

  localparam int ROW_LENGTH = 16;
  localparam int ROW_COUNT  = 2;

  localparam logic [1:0] CFG_SPARE = 2'd3;  // no register behind this index

  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 80;
  localparam int HOLD_AFTER     = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 36;
  localparam int REPORT_LIMIT   = 10;
  localparam int DIR_ROWS       = 27;

  typedef struct packed {
    logic       rs;
    logic [7:0] bus;
    logic       last;
  } xfer_t;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  idx;
    logic [6:0]  data;
    mode_e       mode;
    logic [15:0] value;
    logic [1:0]  row;
    logic [4:0]  col;
    logic        chk;     // expected transfers typed in below
    logic [1:0]  n_xfer;
    logic        rs;
    logic [7:0]  bus0;
    logic [7:0]  bus1;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [6:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // value[15:0], row[17:16], col[22:18], zero[23]
  logic [1:0]  s_axis_tuser  = '0;   // mode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // bus_value[7:0]
  logic        m_axis_tuser;         // reg_select[0]
  logic        m_axis_tlast;

  // shadow of the register file
  logic       four_bit_q  = 1'b1;
  logic       init_done_q = 1'b1;
  logic [6:0] row2_addr_q = 7'd64;

  xfer_t expected_xfers[$];
  int    fail_count   = 0;
  int    results_seen = 0;
  int    quiet_cycles = 0;
  bit    no_gaps      = 1'b0;

  dir_row_t directed_rows [DIR_ROWS] = '{
    // after reset: four-bit, init done, second row at 64
    '{1'b0, 2'd0, 7'd0, MODE_CMD,  16'hff00, 2'd0, 5'd0,  1'b1, 2'd2, 1'b0, 8'h00, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_CMD,  16'h00ff, 2'd0, 5'd0,  1'b1, 2'd2, 1'b0, 8'hf0, 8'hf0},
    '{1'b0, 2'd0, 7'd0, MODE_CHAR, 16'h12a5, 2'd3, 5'd31, 1'b1, 2'd2, 1'b1, 8'ha0, 8'h50},
    '{1'b0, 2'd0, 7'd0, MODE_NUM,  16'd0,    2'd0, 5'd0,  1'b1, 2'd2, 1'b1, 8'h30, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_NUM,  16'hffff, 2'd0, 5'd0,  1'b0, 2'd0, 1'b0, 8'h00, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_NUM,  16'd10,   2'd1, 5'd7,  1'b0, 2'd0, 1'b0, 8'h00, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_NUM,  16'd9,    2'd0, 5'd0,  1'b0, 2'd0, 1'b0, 8'h00, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_GOTO, 16'h0000, 2'd0, 5'd0,  1'b1, 2'd2, 1'b0, 8'h80, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_GOTO, 16'hffff, 2'd1, 5'd15, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00},
    // goto out of range sends nothing
    '{1'b0, 2'd0, 7'd0, MODE_GOTO, 16'h0000, 2'd2, 5'd0,  1'b1, 2'd0, 1'b0, 8'h00, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_GOTO, 16'h0000, 2'd0, 5'd16, 1'b1, 2'd0, 1'b0, 8'h00, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_GOTO, 16'h0000, 2'd3, 5'd31, 1'b1, 2'd0, 1'b0, 8'h00, 8'h00},
    // commands before init keep only the high nibble
    '{1'b1, CFG_INIT_DONE, 7'h7e, MODE_CMD, 16'h0, 2'd0, 5'd0, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_CMD,  16'h003c, 2'd0, 5'd0,  1'b1, 2'd1, 1'b0, 8'h30, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_GOTO, 16'h0000, 2'd1, 5'd3,  1'b0, 2'd0, 1'b0, 8'h00, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_CHAR, 16'h0041, 2'd0, 5'd0,  1'b0, 2'd0, 1'b0, 8'h00, 8'h00},
    // byte mode, second row at the top of the range
    '{1'b1, CFG_FOUR_BIT,  7'h7e, MODE_CMD, 16'h0, 2'd0, 5'd0, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00},
    '{1'b1, CFG_ROW2_ADDR, 7'h7f, MODE_CMD, 16'h0, 2'd0, 5'd0, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_CMD,  16'hffff, 2'd0, 5'd0,  1'b1, 2'd1, 1'b0, 8'hff, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_CHAR, 16'hff00, 2'd0, 5'd0,  1'b1, 2'd1, 1'b1, 8'h00, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_GOTO, 16'h0000, 2'd1, 5'd15, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_NUM,  16'd12345, 2'd0, 5'd0, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00},
    // write to the spare index must not touch the mode
    '{1'b1, CFG_SPARE,     7'h7f, MODE_CMD, 16'h0, 2'd0, 5'd0, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00},
    '{1'b1, CFG_ROW2_ADDR, 7'h00, MODE_CMD, 16'h0, 2'd0, 5'd0, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_GOTO, 16'h0000, 2'd1, 5'd5,  1'b0, 2'd0, 1'b0, 8'h00, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_NUM,  16'd0,    2'd0, 5'd0,  1'b1, 2'd1, 1'b1, 8'h30, 8'h00},
    '{1'b0, 2'd0, 7'd0, MODE_GOTO, 16'h0000, 2'd1, 5'd15, 1'b0, 2'd0, 1'b0, 8'h00, 8'h00}
  };

  char_lcd_write_sequencer_core #(
    .ROW_LENGTH(ROW_LENGTH),
    .ROW_COUNT (ROW_COUNT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic void queue_lcd_byte(logic rs, logic [7:0] b, logic is_cmd);
    if (four_bit_q) begin
      expected_xfers.push_back(xfer_t'{rs, {b[7:4], 4'h0}, 1'b0});
      if (!is_cmd || init_done_q) begin
        expected_xfers.push_back(xfer_t'{rs, {b[3:0], 4'h0}, 1'b0});
      end
    end else begin
      expected_xfers.push_back(xfer_t'{rs, b, 1'b0});
    end
  endfunction

  function automatic void predict_lcd_writes(mode_e m, logic [15:0] v, logic [1:0] r,
                                             logic [4:0] c);
    int unsigned rest;
    int unsigned digit [BCD_DIGITS];
    int          cnt;
    int          start_n;
    logic [7:0]  addr;
    start_n = expected_xfers.size();
    case (m)
      MODE_CMD:  queue_lcd_byte(1'b0, v[7:0], 1'b1);
      MODE_CHAR: queue_lcd_byte(1'b1, v[7:0], 1'b0);
      MODE_NUM: begin
        rest = v;
        cnt  = 0;
        do begin
          digit[cnt] = rest % 10;
          cnt++;
          rest = rest / 10;
        end while (rest > 0 && cnt < BCD_DIGITS);
        for (int i = cnt - 1; i >= 0; i--) begin
          queue_lcd_byte(1'b1, ASCII_ZERO + 8'(digit[i]), 1'b0);
        end
      end
      MODE_GOTO: begin
        if (r < ROW_COUNT && c < ROW_LENGTH) begin
          // the address wraps at 8 bits before the command bit is set
          addr = 8'(int'(r) * int'(row2_addr_q) + int'(c));
          queue_lcd_byte(1'b0, addr | GOTO_CMD, 1'b1);
        end
      end
    endcase
    if (expected_xfers.size() > start_n) begin
      expected_xfers[expected_xfers.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic send_request(mode_e m, logic [15:0] v, logic [1:0] r, logic [4:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= {1'b0, c, r, v};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_item();
    mode_e       m;
    logic [15:0] v;
    logic [1:0]  r;
    logic [4:0]  c;
    m = mode_e'($urandom_range(0, 3));
    v = 16'($urandom);
    r = 2'($urandom);
    c = 5'($urandom);
    if (m == MODE_NUM) begin
      // spread numbers over every digit count
      case ($urandom_range(0, 4))
        0: v = 16'($urandom_range(0, 9));
        1: v = 16'($urandom_range(10, 99));
        2: v = 16'($urandom_range(100, 999));
        3: v = 16'($urandom_range(1000, 9999));
        default: ;
      endcase
    end
    if (m == MODE_GOTO && $urandom_range(0, 4) != 0) begin
      r = 2'($urandom_range(0, ROW_COUNT - 1));
      c = 5'($urandom_range(0, ROW_LENGTH - 1));
    end
    predict_lcd_writes(m, v, r, c);
    send_request(m, v, r, c);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CFG_FOUR_BIT:  four_bit_q  = data[0];
      CFG_INIT_DONE: init_done_q = data[0];
      CFG_ROW2_ADDR: row2_addr_q = data;
      default: ;
    endcase
  endtask

  // an out-of-range goto leaves nothing to wait for, so also let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_xfers.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // receiver: random stalls plus one long hold-off to back up the input
  initial begin
    int stall_left;
    bit long_hold_done;
    int g;
    stall_left     = 0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          stall_left = g - 1;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    xfer_t got;
    xfer_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = xfer_t'{m_axis_tuser, m_axis_tdata, m_axis_tlast};
        results_seen++;
        if (expected_xfers.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: transfer with nothing pending: rs=%0d bus=%02h last=%0d",
                     $realtime, got.rs, got.bus, got.last);
          end
        end else begin
          want = expected_xfers.pop_front();
          if (got.rs !== want.rs || got.bus !== want.bus || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("%0t: transfer mismatch: exp rs=%0d bus=%02h last=%0d, got rs=%0d bus=%02h last=%0d",
                       $realtime, want.rs, want.bus, want.last, got.rs, got.bus, got.last);
            end
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("char_lcd_write_sequencer_core_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t entry;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < DIR_ROWS; k++) begin
      entry = directed_rows[k];
      if (entry.is_cfg) begin
        if (k == 0 || !directed_rows[k - 1].is_cfg) wait_idle();
        write_reg(entry.idx, entry.data);
      end else begin
        if (entry.chk) begin
          for (int j = 0; j < entry.n_xfer; j++) begin
            expected_xfers.push_back(xfer_t'{entry.rs, (j == 0) ? entry.bus0 : entry.bus1,
                                             j == entry.n_xfer - 1});
          end
        end else begin
          predict_lcd_writes(entry.mode, entry.value, entry.row, entry.col);
        end
        send_request(entry.mode, entry.value, entry.row, entry.col);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      no_gaps = (p == 2 || p == 5);
      case (p)
        0: begin
          write_reg(CFG_FOUR_BIT,  {6'($urandom), 1'b1});
          write_reg(CFG_INIT_DONE, {6'($urandom), 1'b1});
          write_reg(CFG_ROW2_ADDR, 7'h7f);
        end
        1: begin
          write_reg(CFG_FOUR_BIT,  {6'($urandom), 1'b0});
          write_reg(CFG_INIT_DONE, {6'($urandom), 1'b0});
          write_reg(CFG_ROW2_ADDR, 7'h00);
        end
        2: begin
          write_reg(CFG_FOUR_BIT,  {6'($urandom), 1'b1});
          write_reg(CFG_INIT_DONE, {6'($urandom), 1'b0});
          write_reg(CFG_ROW2_ADDR, 7'($urandom));
        end
        default: begin
          write_reg(CFG_FOUR_BIT,  7'($urandom));
          write_reg(CFG_INIT_DONE, 7'($urandom));
          write_reg(CFG_ROW2_ADDR, 7'($urandom));
        end
      endcase
      write_reg(CFG_SPARE, 7'($urandom));
      repeat (PHASE_ITEMS) send_random_item();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("char_lcd_write_sequencer_core_tb: done, clean");
    end else begin
      $display("char_lcd_write_sequencer_core_tb: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/clsq_pkg.sv
rtl/clsq_bcd.sv
rtl/char_lcd_write_sequencer_core.sv
tb/char_lcd_write_sequencer_core_tb.sv
